@@ src/lsmm_pkg.sv @@
// Shared types and constants of the linear sieve / Moebius / Mertens block.
`timescale 1ns / 1ps

package lsmm_pkg;

  // Fixed field widths on the ports
  localparam int unsigned NUM_W  = 13;  // number, least_factor, limit
  localparam int unsigned MU_W   = 2;   // Moebius value, two's complement
  localparam int unsigned MERT_W = 14;  // running Mertens sum

  // Stream payload sizes (bytes filled with zeros)
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_USED_W  = NUM_W + MU_W + MERT_W + NUM_W + 1;

  // Moebius codes
  localparam logic [MU_W-1:0] MU_ZERO = 2'b00;
  localparam logic [MU_W-1:0] MU_ONE  = 2'b01;
  localparam logic [MU_W-1:0] MU_NEG  = 2'b11;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,  // sweep zeros through the sieve table
    ST_IDLE  = 8'b0000_0010,  // waiting for an input beat
    ST_CHECK = 8'b0000_0100,  // limit test, table read issued
    ST_READ  = 8'b0000_1000,  // table entry of n back
    ST_PREAD = 8'b0001_0000,  // issue prime list read
    ST_PMUL  = 8'b0010_0000,  // n * p into the product register
    ST_PMARK = 8'b0100_0000,  // mark n * p in the table
    ST_DONE  = 8'b1000_0000   // hand result to the output register
  } lsmm_state_t;

  // Prime list control from the sequencer
  typedef struct packed {
    logic clear;   // drop all primes (restart)
    logic append;  // add a newly found prime
  } lsmm_plist_ctl_t;

endpackage

@@ src/lsmm_table.sv @@
// Sieve table memory: least factor and Moebius value per integer.
`timescale 1ns / 1ps

module lsmm_table #(
  parameter int unsigned DEPTH = 4097,
  parameter int unsigned AW    = 13,
  parameter int unsigned DW    = 15
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/lsmm_plist.sv @@
// Prime list: memory of found primes plus its fill count.
`timescale 1ns / 1ps

module lsmm_plist #(
  parameter int unsigned SLOTS = 1024,
  parameter int unsigned NW    = 13,
  parameter int unsigned IW    = 10,
  parameter int unsigned CW    = 11
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lsmm_pkg::lsmm_plist_ctl_t ctl,
  input  logic [NW-1:0]            append_val,
  input  logic [IW-1:0]            rd_addr,
  output logic [NW-1:0]            rd_data,
  output logic [CW-1:0]            count
);

  logic [NW-1:0] mem [SLOTS];
  logic          room;

  assign room = (count < CW'(SLOTS));

  // Fill count; a full list silently drops further primes
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count <= '0;
    end else if (ctl.append && room) begin
      count <= count + CW'(1);
    end
  end

  // Append at the fill point, registered read
  always_ff @(posedge clk) begin
    if (ctl.append && room && !ctl.clear) begin
      mem[count[IW-1:0]] <= append_val;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/linear_sieve_mobius_mertens.sv @@
// Linear sieve stepping one integer per beat: Moebius value, Mertens sum, least factor.
//
// Use: each input beat on s_* advances to the next integer n and yields one
// result beat on m_*. s_tdata[0] = restart: the tables are cleared and the
// beat processes n = 1. The limit register is written over cfg_*, which is
// always ready; write it only while the block is idle. Values above MAX_N
// act as MAX_N. Once n passes the limit each beat returns past_limit set
// (m_tuser) with all other fields zero, and nothing changes.
// After the limit test and the table read of n, a step walks the stored
// primes, each by a prime list read, the product register and a table
// write; the walk ends at the least factor of n or when n*p passes the
// limit, or when it runs off the end of a full prime list. n = 1 and
// past-limit beats skip the table read and the walk. Only one item is in
// work at a time; the next beat is taken in the idle state that follows
// the result.
// A restart beat first sweeps zeros over table entries 0 up to the highest
// one written, one entry a cycle. After reset the whole table is swept
// with s_tready low; the limit resets to 4096.
// A finished result waits in the output register while the next beat is
// taken; a step whose result finds that register still full waits for it.
`timescale 1ns / 1ps

module linear_sieve_mobius_mertens #(
  parameter int unsigned MAX_N       = 4096,
  parameter int unsigned PRIME_SLOTS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lsmm_pkg::IN_TDATA_W-1:0]   s_tdata,   // [0] restart
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lsmm_pkg::OUT_TDATA_W-1:0]  m_tdata,   // number, mobius, mertens,
                                                       // least_factor, is_prime
  output logic                              m_tuser,   // past_limit
  // limit register write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsmm_pkg::NUM_W-1:0]        cfg_data   // limit
);

  localparam int unsigned NW  = $clog2(MAX_N + 1);        // table index
  localparam int unsigned NNW = NW + 1;                   // n, may pass MAX_N
  localparam int unsigned PW  = NNW + NW;                 // product n * p
  localparam int unsigned TW  = NW + lsmm_pkg::MU_W;      // table word
  localparam int unsigned IW  = $clog2(PRIME_SLOTS);
  localparam int unsigned CW  = $clog2(PRIME_SLOTS + 1);
  localparam int unsigned MW  = lsmm_pkg::MERT_W;
  localparam int unsigned UW  = lsmm_pkg::MU_W;

  lsmm_pkg::lsmm_state_t state;

  logic [lsmm_pkg::NUM_W-1:0] limit;
  logic [NW-1:0]  lim_eff;
  logic [NW-1:0]  clr_addr;
  logic [NW-1:0]  clr_end;
  logic           pend;
  logic [NW-1:0]  hwm;
  logic [NNW-1:0] n;
  logic [MW-1:0]  mertens;
  logic [MW-1:0]  mertens_next;
  logic [CW-1:0]  i;
  logic [NW-1:0]  cur_lf;
  logic [UW-1:0]  cur_mu;
  logic           cur_prime;
  logic           cur_past;
  logic [NW-1:0]  cur_p;
  logic [PW-1:0]  prod;
  logic           out_free;

  // table ports
  logic           tbl_wr_en;
  logic [NW-1:0]  tbl_wr_addr;
  logic [TW-1:0]  tbl_wr_data;
  logic [TW-1:0]  tbl_rd_data;
  logic [NW-1:0]  tbl_lf;
  logic [UW-1:0]  tbl_mu;

  // prime list ports
  lsmm_pkg::lsmm_plist_ctl_t plist_ctl;
  logic [NW-1:0]  plist_rd_data;
  logic [CW-1:0]  plist_count;

  logic           accept;
  logic           past;
  logic           prod_over;
  logic           at_lf;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == lsmm_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Effective limit: register saturated at MAX_N, the highest table index
  assign lim_eff = ({19'd0, limit} > 32'(MAX_N)) ? NW'(MAX_N) : NW'(limit);
  assign past    = (n > NNW'(lim_eff));
  assign prod_over = (prod > PW'(lim_eff));
  assign at_lf   = (cur_p == cur_lf);

  assign tbl_lf = tbl_rd_data[NW-1:0];
  assign tbl_mu = tbl_rd_data[TW-1:NW];

  assign mertens_next = mertens + {{(MW-UW){cur_mu[UW-1]}}, cur_mu};

  // Table write source by state
  always_comb begin
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = clr_addr;
    tbl_wr_data = '0;
    unique case (state)
      lsmm_pkg::ST_CLEAR: begin
        tbl_wr_en = 1'b1;
      end
      lsmm_pkg::ST_READ: begin
        tbl_wr_en   = (tbl_lf == '0);
        tbl_wr_addr = n[NW-1:0];
        tbl_wr_data = {lsmm_pkg::MU_NEG, n[NW-1:0]};
      end
      lsmm_pkg::ST_PMARK: begin
        tbl_wr_en   = !prod_over;
        tbl_wr_addr = prod[NW-1:0];
        tbl_wr_data = {(at_lf ? lsmm_pkg::MU_ZERO : (lsmm_pkg::MU_ZERO - cur_mu)), cur_p};
      end
      default: begin
        tbl_wr_en = 1'b0;
      end
    endcase
  end

  // Prime list control
  always_comb begin
    plist_ctl.clear  = accept && s_tdata[0];
    plist_ctl.append = (state == lsmm_pkg::ST_READ) && (tbl_lf == '0);
  end

  lsmm_table #(
    .DEPTH (MAX_N + 1),
    .AW    (NW),
    .DW    (TW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (n[NW-1:0]),
    .rd_data (tbl_rd_data)
  );

  lsmm_plist #(
    .SLOTS (PRIME_SLOTS),
    .NW    (NW),
    .IW    (IW),
    .CW    (CW)
  ) u_plist (
    .clk        (clk),
    .rst        (rst),
    .ctl        (plist_ctl),
    .append_val (n[NW-1:0]),
    .rd_addr    (i[IW-1:0]),
    .rd_data    (plist_rd_data),
    .count      (plist_count)
  );

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lsmm_pkg::ST_CLEAR;
      clr_addr <= '0;
      clr_end  <= NW'(MAX_N);
      pend     <= 1'b0;
      hwm      <= '0;
      n        <= NNW'(1);
      mertens  <= '0;
      i        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !((state == lsmm_pkg::ST_DONE) && out_free)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        lsmm_pkg::ST_CLEAR: begin
          if (clr_addr == clr_end) begin
            state <= pend ? lsmm_pkg::ST_CHECK : lsmm_pkg::ST_IDLE;
            pend  <= 1'b0;
          end else begin
            clr_addr <= clr_addr + NW'(1);
          end
        end
        lsmm_pkg::ST_IDLE: begin
          if (accept) begin
            if (s_tdata[0]) begin
              // restart: wipe what was written, then do n = 1
              state    <= lsmm_pkg::ST_CLEAR;
              pend     <= 1'b1;
              clr_addr <= '0;
              clr_end  <= hwm;
              hwm      <= '0;
              n        <= NNW'(1);
              mertens  <= '0;
            end else begin
              state <= lsmm_pkg::ST_CHECK;
            end
          end
        end
        lsmm_pkg::ST_CHECK: begin
          cur_prime <= 1'b0;
          cur_past  <= past;
          if (past) begin
            cur_mu <= lsmm_pkg::MU_ZERO;
            cur_lf <= '0;
            state  <= lsmm_pkg::ST_DONE;
          end else if (n == NNW'(1)) begin
            cur_mu <= lsmm_pkg::MU_ONE;
            cur_lf <= '0;
            state  <= lsmm_pkg::ST_DONE;
          end else begin
            state <= lsmm_pkg::ST_READ;
          end
        end
        lsmm_pkg::ST_READ: begin
          if (tbl_lf == '0) begin
            // empty entry: n is prime
            cur_lf    <= n[NW-1:0];
            cur_mu    <= lsmm_pkg::MU_NEG;
            cur_prime <= 1'b1;
            if (n[NW-1:0] > hwm) begin
              hwm <= n[NW-1:0];
            end
          end else begin
            cur_lf <= tbl_lf;
            cur_mu <= tbl_mu;
          end
          i     <= '0;
          state <= lsmm_pkg::ST_PREAD;
        end
        lsmm_pkg::ST_PREAD: begin
          state <= (i >= plist_count) ? lsmm_pkg::ST_DONE : lsmm_pkg::ST_PMUL;
        end
        lsmm_pkg::ST_PMUL: begin
          prod  <= PW'(n) * PW'(plist_rd_data);
          cur_p <= plist_rd_data;
          state <= lsmm_pkg::ST_PMARK;
        end
        lsmm_pkg::ST_PMARK: begin
          if (prod_over) begin
            state <= lsmm_pkg::ST_DONE;
          end else begin
            if (prod[NW-1:0] > hwm) begin
              hwm <= prod[NW-1:0];
            end
            if (at_lf) begin
              state <= lsmm_pkg::ST_DONE;
            end else begin
              i     <= i + CW'(1);
              state <= lsmm_pkg::ST_PREAD;
            end
          end
        end
        lsmm_pkg::ST_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= lsmm_pkg::ST_IDLE;
            if (!cur_past) begin
              mertens <= mertens_next;
              n       <= n + NNW'(1);
            end
          end
        end
        default: begin
          state <= lsmm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if ((state == lsmm_pkg::ST_DONE) && out_free) begin
      m_tuser <= cur_past;
      if (cur_past) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {(lsmm_pkg::OUT_TDATA_W - lsmm_pkg::OUT_USED_W)'(0),
                    cur_prime,
                    lsmm_pkg::NUM_W'(cur_lf),
                    mertens_next,
                    cur_mu,
                    lsmm_pkg::NUM_W'(n)};
      end
    end
  end

endmodule

@@ tb/sv/linear_sieve_mobius_mertens_test.sv @@
// Self-checking testbench for the linear sieve Moebius / Mertens stream block.
`timescale 1ns / 1ps

module linear_sieve_mobius_mertens_test;

  localparam int unsigned SIEVE_TOP   = 4096;
  localparam int unsigned PRIME_DEPTH = 1024;

  // result beat layout on m_tdata, lowest field first
  localparam int unsigned NUMBER_LO = 0;
  localparam int unsigned MU_LO     = NUMBER_LO + lsmm_pkg::NUM_W;
  localparam int unsigned MERT_LO   = MU_LO + lsmm_pkg::MU_W;
  localparam int unsigned LF_LO     = MERT_LO + lsmm_pkg::MERT_W;
  localparam int unsigned PRIME_BIT = LF_LO + lsmm_pkg::NUM_W;

  typedef enum logic [1:0] {
    JOB_BEAT,   // one input beat
    JOB_LIMIT,  // limit register write, block idle
    JOB_PACE    // change of idling rates
  } job_kind_t;

  typedef struct packed {
    job_kind_t                  kind;
    logic                       restart;
    logic [lsmm_pkg::NUM_W-1:0] value;
    logic [6:0]                 gap;
    logic [6:0]                 stall;
  } job_t;

  typedef struct packed {
    logic [lsmm_pkg::NUM_W-1:0]  number;
    logic [lsmm_pkg::MU_W-1:0]   mobius;
    logic [lsmm_pkg::MERT_W-1:0] mertens;
    logic [lsmm_pkg::NUM_W-1:0]  least_factor;
    logic                        is_prime;
    logic                        past_limit;
  } sieve_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [lsmm_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // [0] restart
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [lsmm_pkg::OUT_TDATA_W-1:0] m_tdata;        // number, mobius, mertens,
                                                    // least_factor, is_prime
  logic                             m_tuser;        // past_limit
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [lsmm_pkg::NUM_W-1:0]       cfg_data = '0;  // limit

  linear_sieve_mobius_mertens #(
    .MAX_N      (SIEVE_TOP),
    .PRIME_SLOTS(PRIME_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // sieve mirror: tables, prime list, counters, limit
  logic [lsmm_pkg::NUM_W-1:0]  lf_tab [0:SIEVE_TOP];
  logic [lsmm_pkg::MU_W-1:0]   mu_tab [0:SIEVE_TOP];
  logic [lsmm_pkg::NUM_W-1:0]  primes [0:PRIME_DEPTH-1];
  int unsigned                 prime_cnt;
  int unsigned                 cur_n;
  logic [lsmm_pkg::MERT_W-1:0] mert_sum;
  logic [lsmm_pkg::NUM_W-1:0]  limit_reg;

  job_t          job_q[$];
  sieve_result_t sieve_expect[$];
  int unsigned   gap_pct = 0;
  int unsigned   stall_pct = 0;
  int unsigned   fail_count = 0;
  int unsigned   beat_count = 0;
  int unsigned   restart_count = 0;
  longint unsigned cycle_cap = 64'd10_000_000;
  longint unsigned cycles = 0;

  function automatic void wipe_sieve();
    for (int i = 0; i <= SIEVE_TOP; i++) begin
      lf_tab[i] = '0;
      mu_tab[i] = lsmm_pkg::MU_ZERO;
    end
    prime_cnt = 0;
    cur_n     = 1;
    mert_sum  = '0;
  endfunction

  // Advance the sieve by one integer (not once past the limit) and return the beat it should produce
  function automatic sieve_result_t sieve_step(logic restart);
    sieve_result_t              r;
    int unsigned                lim;
    int unsigned                n;
    int unsigned                p;
    int unsigned                m;
    logic [lsmm_pkg::MU_W-1:0]  mu;
    logic [lsmm_pkg::NUM_W-1:0] lf;
    logic                       fresh;
    r     = '0;
    fresh = 1'b0;
    lim   = (limit_reg > SIEVE_TOP) ? SIEVE_TOP : limit_reg;
    if (restart) wipe_sieve();
    n = cur_n;
    if (n > lim) begin
      r.past_limit = 1'b1;
      return r;
    end
    if (n == 1) begin
      mu = lsmm_pkg::MU_ONE;
      lf = '0;
    end else begin
      // empty entry: n is prime
      if (lf_tab[n] == '0) begin
        lf_tab[n] = n[lsmm_pkg::NUM_W-1:0];
        mu_tab[n] = lsmm_pkg::MU_NEG;
        fresh     = 1'b1;
        if (prime_cnt < PRIME_DEPTH) begin
          primes[prime_cnt] = n[lsmm_pkg::NUM_W-1:0];
          prime_cnt++;
        end
      end
      lf = lf_tab[n];
      mu = mu_tab[n];
      // mark n*p for primes up to the least factor of n
      for (int i = 0; i < prime_cnt; i++) begin
        p = primes[i];
        m = n * p;
        if (m > lim) break;
        lf_tab[m] = p[lsmm_pkg::NUM_W-1:0];
        if (p == lf) begin
          mu_tab[m] = lsmm_pkg::MU_ZERO;
          break;
        end
        mu_tab[m] = -mu;
      end
    end
    mert_sum = mert_sum + {{(lsmm_pkg::MERT_W-lsmm_pkg::MU_W){mu[lsmm_pkg::MU_W-1]}}, mu};
    cur_n    = n + 1;
    r.number       = n[lsmm_pkg::NUM_W-1:0];
    r.mobius       = mu;
    r.mertens      = mert_sum;
    r.least_factor = lf;
    r.is_prime     = fresh;
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Append one job at the tail of the queue
  task automatic enqueue_job(job_t j);
    job_q.insert(job_q.size(), j);
  endtask

  task automatic add_beat(logic restart);
    job_t j;
    j = '0;
    j.kind    = JOB_BEAT;
    j.restart = restart;
    enqueue_job(j);
    beat_count++;
    if (restart) restart_count++;
  endtask

  task automatic add_limit(int unsigned v);
    job_t j;
    j = '0;
    j.kind  = JOB_LIMIT;
    j.value = v[lsmm_pkg::NUM_W-1:0];
    enqueue_job(j);
  endtask

  task automatic add_pace(int unsigned g, int unsigned s);
    job_t j;
    j = '0;
    j.kind  = JOB_PACE;
    j.gap   = g[6:0];
    j.stall = s[6:0];
    enqueue_job(j);
  endtask

  // Runs of the sieve under random limits; mostly restart then step on
  task automatic add_random_runs(int unsigned quota);
    int unsigned made;
    int unsigned sel;
    int unsigned lim;
    int unsigned run;
    made = 0;
    while (made < quota) begin
      sel = $urandom_range(99);
      if (sel < 70) lim = $urandom_range(2, 300);
      else if (sel < 80) lim = $urandom_range(301, 4095);
      else if (sel < 90) lim = SIEVE_TOP;
      else lim = $urandom_range(4097, 8191);
      add_limit(lim);
      // otherwise carry on under the new limit
      if ($urandom_range(99) < 75) begin
        add_beat(1'b1);
        made++;
      end
      run = (lim < 300) ? $urandom_range(1, lim + 5) : $urandom_range(5, 150);
      for (int k = 0; k < run; k++) begin
        add_beat($urandom_range(99) < 3);
        made++;
      end
    end
  endtask

  // Stimulus, reset and end of run
  initial begin
    wipe_sieve();
    for (int i = 0; i < PRIME_DEPTH; i++) primes[i] = '0;
    limit_reg = SIEVE_TOP;

    // directed: lowest limit, then raised mid-run so 4 counts as prime
    add_pace(11, 45);
    add_limit(2);
    add_beat(1'b1);
    repeat (3) add_beat(1'b0);
    add_limit(30);
    repeat (8) add_beat(1'b0);
    add_beat(1'b1);
    repeat (4) add_beat(1'b0);
    // register above the table size
    add_limit(8191);
    repeat (2) add_beat(1'b0);

    add_random_runs(500);
    add_pace(45, 11);
    add_random_runs(500);
    add_pace(0, 0);
    add_random_runs(400);

    // one long run under the full table size
    add_limit(SIEVE_TOP);
    add_beat(1'b1);
    repeat (600) add_beat(1'b0);

    cycle_cap = 20000 + 4 * (longint'(beat_count) * 100 +
                longint'(restart_count + 1) * 4200);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (job_q.size() != 0 || sieve_expect.size() != 0 || s_tvalid || cfg_valid)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("linear_sieve_mobius_mertens regression: pass");
    end else begin
      $display("linear_sieve_mobius_mertens regression: fail");
    end
    $finish;
  end

  // Driver: input beats and limit writes from the job queue
  always @(posedge clk) begin : drive
    job_t                            head;
    sieve_result_t                   predicted;
    logic                            next_svalid;
    logic                            next_cvalid;
    logic [lsmm_pkg::IN_TDATA_W-1:0] next_sdata;
    logic [lsmm_pkg::NUM_W-1:0]      next_cdata;
    if (rst) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= '0;
      cfg_valid <= 1'b0;
      cfg_data  <= '0;
    end else begin
      next_svalid = s_tvalid;
      next_sdata  = s_tdata;
      next_cvalid = cfg_valid;
      next_cdata  = cfg_data;
      if (s_tvalid && s_tready) begin
        predicted = sieve_step(s_tdata[0]);
        sieve_expect.insert(sieve_expect.size(), predicted);
        next_svalid = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        limit_reg   = cfg_data;
        next_cvalid = 1'b0;
      end
      if (!next_svalid && !next_cvalid && job_q.size() != 0) begin
        head = job_q[0];
        case (head.kind)
          JOB_PACE: begin
            gap_pct   = head.gap;
            stall_pct = head.stall;
            void'(job_q.pop_front());
          end
          JOB_LIMIT: begin
            // only once every result is out and the block takes beats
            if (sieve_expect.size() == 0 && s_tready) begin
              next_cvalid = 1'b1;
              next_cdata  = head.value;
              void'(job_q.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= gap_pct) begin
              next_svalid = 1'b1;
              next_sdata  = '0;
              next_sdata[0] = head.restart;
              void'(job_q.pop_front());
            end
          end
        endcase
      end
      s_tvalid  <= next_svalid;
      s_tdata   <= next_sdata;
      cfg_valid <= next_cvalid;
      cfg_data  <= next_cdata;
    end
  end

  // Monitor: random back-pressure and field checks on each result beat
  always @(posedge clk) begin : watch
    sieve_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (sieve_expect.size() == 0) begin
          $display("%0t: result beat with none expected, actual tdata %0h tuser %0b",
                   $time, m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = sieve_expect.pop_front();
          check_field("number", want.number, m_tdata[NUMBER_LO +: lsmm_pkg::NUM_W]);
          check_field("mobius", want.mobius, m_tdata[MU_LO +: lsmm_pkg::MU_W]);
          check_field("mertens", want.mertens, m_tdata[MERT_LO +: lsmm_pkg::MERT_W]);
          check_field("least_factor", want.least_factor,
                      m_tdata[LF_LO +: lsmm_pkg::NUM_W]);
          check_field("is_prime", want.is_prime, m_tdata[PRIME_BIT]);
          check_field("padding", 0,
                      m_tdata[lsmm_pkg::OUT_TDATA_W-1:lsmm_pkg::OUT_USED_W]);
          check_field("past_limit", want.past_limit, m_tuser);
        end
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > cycle_cap) begin
      $display("linear_sieve_mobius_mertens regression: fail");
      $finish;
    end
  end

endmodule

@@ sim.f @@
src/lsmm_pkg.sv
src/lsmm_table.sv
src/lsmm_plist.sv
src/linear_sieve_mobius_mertens.sv
tb/sv/linear_sieve_mobius_mertens_test.sv
